FILE: sv/cipa_pkg.sv
// Shared types, constants and helper functions for the connection ID pool allocator.
package cipa_pkg;

  // Widths of the interface fields.
  localparam int unsigned ID_W   = 12;
  localparam int unsigned USE_W  = 32;
  localparam int unsigned STAT_W = 48;

  // Default number of IDs the pool can hold.
  localparam int unsigned POOL_DEPTH_DEF = 2048;

  // Smallest number of IDs loaded onto the free stack by a clear.
  localparam int unsigned MIN_PREFILL = 4;

  // Limit register value after reset.
  localparam logic [ID_W-1:0] MAX_ENTRIES_RST = 12'd2000;

  // Use counts saturate at this value.
  localparam logic [USE_W-1:0] USE_MAX = '1;

  // Request codes.
  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  // Result codes.
  typedef enum logic [2:0] {
    STAT_REUSED    = 3'd0,
    STAT_CREATED   = 3'd1,
    STAT_EXHAUSTED = 3'd2,
    STAT_RELEASED  = 3'd3,
    STAT_INVALID   = 3'd4
  } status_t;

  // Input beat.
  typedef struct packed {
    cmd_t            command;
    logic [ID_W-1:0] entry_id;
  } in_t;

  // Result beat.
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   granted_id;
    logic [USE_W-1:0]  grant_uses;
    logic [ID_W-1:0]   idle_count;
    logic [ID_W-1:0]   active_count;
    logic [ID_W-1:0]   created_count;
    logic [STAT_W-1:0] acquired_total;
    logic [STAT_W-1:0] released_total;
    logic [STAT_W-1:0] created_total;
    logic [STAT_W-1:0] reuse_total;
    logic [STAT_W-1:0] error_total;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic lookup;
    logic commit;
    logic clr_wr;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic pop_avail;
    logic out_free;
  } dp_stat_t;

  // Number of IDs a clear places on the free stack: a quarter of the limit,
  // at least MIN_PREFILL and at most the pool depth.
  function automatic int unsigned prefill(input logic [ID_W-1:0] lim,
                                          input int unsigned depth);
    int unsigned q;
    q = 32'(lim >> 2);
    if (q < MIN_PREFILL) q = MIN_PREFILL;
    if (q > depth) q = depth;
    return q;
  endfunction

endpackage

FILE: sv/connection_id_pool_allocator.sv
// Top level of the connection ID pool allocator.
//
// Connection IDs 1..POOL_DEPTH are handed out from a LIFO free stack. After
// reset, and after every write to the limit register, a clear pass walks the
// whole pool one entry per cycle while in_ready stays low; it zeroes use
// counts and active flags and leaves max(limit/4, 4) IDs on the stack with
// the highest on top. One request is in flight at a time. A release, an
// on-demand creation or an exhausted acquire goes from IDLE straight to
// EXEC; an acquire served from the free stack passes through LOOKUP first,
// because the popped ID must be read from the stack memory before its use
// count can be read from the use-count memory. The result sits in an output
// register, so the next request is taken while it waits.
module connection_id_pool_allocator #(
  parameter int unsigned POOL_DEPTH = cipa_pkg::POOL_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cipa_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cipa_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  logic [cipa_pkg::ID_W-1:0] cfg_wdata
);

  cipa_pkg::ctrl_cmd_t cmd;
  cipa_pkg::dp_stat_t  stat;

  // Sequencer.
  cipa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  cipa_dp #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sv/cipa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cipa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/cipa_ctrl.sv
// Controller state machine that sequences clears and requests through the datapath.
module cipa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cipa_pkg::dp_stat_t   stat,
  output cipa_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // A limit write wins over an input beat in the same cycle.
  assign in_ready = in_ready_r & ~cfg_we;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.pop_avail ? S_LOOKUP : S_EXEC;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // A limit write restarts the clear from any state.
    if (cfg_we) begin
      cmd       = '0;
      state_nxt = S_CLEAR;
    end
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

FILE: sv/cipa_dp.sv
// Datapath: free stack, use counts, active flags, counters and the result register.
module cipa_dp #(
  parameter int unsigned POOL_DEPTH = cipa_pkg::POOL_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cipa_pkg::ID_W-1:0]    cfg_wdata,
  input  cipa_pkg::in_t                in_data,
  input  cipa_pkg::ctrl_cmd_t          cmd,
  output cipa_pkg::dp_stat_t           stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output cipa_pkg::out_t               out_data
);

  localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
  localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > cipa_pkg::ID_W) ? CNT_W : cipa_pkg::ID_W;
  localparam int unsigned ID_W  = cipa_pkg::ID_W;
  localparam int unsigned USE_W = cipa_pkg::USE_W;
  localparam int unsigned ST_W  = cipa_pkg::STAT_W;

  localparam logic [CW-1:0]    DEPTH_C  = CW'(POOL_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);
  localparam logic [CNT_W-1:0] RST_FILL =
    CNT_W'(cipa_pkg::prefill(cipa_pkg::MAX_ENTRIES_RST, POOL_DEPTH));

  // Control and counter registers.
  logic [ID_W-1:0]  max_r, max_nxt;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] created_r, created_nxt;
  logic [CNT_W-1:0] act_r, act_nxt;
  logic [ST_W-1:0]  acq_r, acq_nxt;
  logic [ST_W-1:0]  rel_r, rel_nxt;
  logic [ST_W-1:0]  cre_r, cre_nxt;
  logic [ST_W-1:0]  reuse_r, reuse_nxt;
  logic [ST_W-1:0]  err_r, err_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  cipa_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             pop_r, pop_nxt;
  cipa_pkg::out_t   out_r, out_nxt;

  // Memory ports.
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic             act_we, act_re;
  logic [IDX_W-1:0] act_waddr, act_raddr;
  logic             act_wdata, act_rdata;
  logic             use_we;
  logic [IDX_W-1:0] use_waddr;
  logic [USE_W-1:0] use_wdata, use_rdata;

  // Decode of the pending request.
  logic [CNT_W-1:0] cfg_fill;
  logic [CNT_W-1:0] top_m1;
  logic [CW-1:0]    id_ext, id_m1, in_m1;
  logic [IDX_W-1:0] id_slot, grant_slot;
  logic             is_rel, rel_ok, can_create, grant;
  logic [USE_W-1:0] use_inc;

  assign cfg_fill   = CNT_W'(cipa_pkg::prefill(cfg_wdata, POOL_DEPTH));
  assign top_m1     = top_r - CNT_W'(1);
  assign id_ext     = CW'(id_r);
  assign id_m1      = id_ext - CW'(1);
  assign id_slot    = id_m1[IDX_W-1:0];
  assign in_m1      = CW'(in_data.entry_id) - CW'(1);
  assign is_rel     = (cmd_r == cipa_pkg::CMD_RELEASE);
  assign can_create = (CW'(created_r) < CW'(max_r)) && (CW'(created_r) < DEPTH_C);
  assign grant      = !is_rel && (pop_r || can_create);
  assign grant_slot = pop_r ? stk_rdata : created_r[IDX_W-1:0];
  assign use_inc    = (use_rdata == cipa_pkg::USE_MAX) ? use_rdata
                                                       : use_rdata + USE_W'(1);

  // A release is honored only for an existing, active ID with room on the stack.
  assign rel_ok = (id_r != '0) && (id_ext <= CW'(created_r)) && (id_ext <= DEPTH_C) &&
                  act_rdata && (CW'(top_r) < DEPTH_C);

  // Free stack memory: the clear writes each slot with its own index.
  assign stk_we    = cmd.clr_wr || (cmd.commit && is_rel && rel_ok);
  assign stk_waddr = cmd.clr_wr ? clr_addr_r : top_r[IDX_W-1:0];
  assign stk_wdata = cmd.clr_wr ? clr_addr_r : id_slot;
  assign stk_re    = cmd.accept;
  assign stk_raddr = top_m1[IDX_W-1:0];

  // Active flag memory: read for the released ID when the beat is taken.
  assign act_we    = cmd.clr_wr || (cmd.commit && (grant || (is_rel && rel_ok)));
  assign act_waddr = cmd.clr_wr ? clr_addr_r : (is_rel ? id_slot : grant_slot);
  assign act_wdata = !cmd.clr_wr && !is_rel;
  assign act_re    = cmd.accept;
  assign act_raddr = in_m1[IDX_W-1:0];

  // Use count memory: read at the popped slot in the lookup cycle.
  assign use_we    = cmd.clr_wr || (cmd.commit && grant);
  assign use_waddr = cmd.clr_wr ? clr_addr_r : grant_slot;
  assign use_wdata = cmd.clr_wr ? '0 : (pop_r ? use_inc : USE_W'(1));

  cipa_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  cipa_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .re    (act_re),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  cipa_ram #(.WIDTH(USE_W), .DEPTH(POOL_DEPTH)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_waddr),
    .wdata (use_wdata),
    .re    (cmd.lookup),
    .raddr (stk_rdata),
    .rdata (use_rdata)
  );

  // Next values of counters and the result beat.
  always_comb begin
    max_nxt       = max_r;
    top_nxt       = top_r;
    created_nxt   = created_r;
    act_nxt       = act_r;
    acq_nxt       = acq_r;
    rel_nxt       = rel_r;
    cre_nxt       = cre_r;
    reuse_nxt     = reuse_r;
    err_nxt       = err_r;
    clr_addr_nxt  = clr_addr_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    pop_nxt       = pop_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.clr_wr) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
    end

    if (cmd.accept) begin
      cmd_nxt = in_data.command;
      id_nxt  = in_data.entry_id;
      pop_nxt = stat.pop_avail;
    end

    if (cmd.commit) begin
      out_nxt.status     = cipa_pkg::STAT_INVALID;
      out_nxt.granted_id = '0;
      out_nxt.grant_uses = '0;
      if (!is_rel) begin
        priority if (pop_r) begin
          out_nxt.status     = cipa_pkg::STAT_REUSED;
          out_nxt.granted_id = ID_W'(CNT_W'(stk_rdata) + CNT_W'(1));
          out_nxt.grant_uses = use_inc;
          top_nxt            = top_m1;
          act_nxt            = act_r + CNT_W'(1);
          acq_nxt            = acq_r + ST_W'(1);
          reuse_nxt          = reuse_r + ST_W'(1);
        end else if (can_create) begin
          out_nxt.status     = cipa_pkg::STAT_CREATED;
          out_nxt.granted_id = ID_W'(created_r + CNT_W'(1));
          out_nxt.grant_uses = USE_W'(1);
          created_nxt        = created_r + CNT_W'(1);
          act_nxt            = act_r + CNT_W'(1);
          acq_nxt            = acq_r + ST_W'(1);
          cre_nxt            = cre_r + ST_W'(1);
        end else begin
          out_nxt.status = cipa_pkg::STAT_EXHAUSTED;
          err_nxt        = err_r + ST_W'(1);
        end
      end else if (rel_ok) begin
        out_nxt.status = cipa_pkg::STAT_RELEASED;
        top_nxt        = top_r + CNT_W'(1);
        if (act_r != '0) begin
          act_nxt = act_r - CNT_W'(1);
        end
        rel_nxt = rel_r + ST_W'(1);
      end
      out_nxt.idle_count     = ID_W'(top_nxt);
      out_nxt.active_count   = ID_W'(act_nxt);
      out_nxt.created_count  = ID_W'(created_nxt);
      out_nxt.acquired_total = acq_nxt;
      out_nxt.released_total = rel_nxt;
      out_nxt.created_total  = cre_nxt;
      out_nxt.reuse_total    = reuse_nxt;
      out_nxt.error_total    = err_nxt;
      out_valid_nxt          = 1'b1;
    end

    // A limit write starts a fresh pool.
    if (cfg_we) begin
      max_nxt      = cfg_wdata;
      top_nxt      = cfg_fill;
      created_nxt  = cfg_fill;
      act_nxt      = '0;
      acq_nxt      = '0;
      rel_nxt      = '0;
      cre_nxt      = '0;
      reuse_nxt    = '0;
      err_nxt      = '0;
      clr_addr_nxt = '0;
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= cipa_pkg::MAX_ENTRIES_RST;
      top_r       <= RST_FILL;
      created_r   <= RST_FILL;
      act_r       <= '0;
      acq_r       <= '0;
      rel_r       <= '0;
      cre_r       <= '0;
      reuse_r     <= '0;
      err_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_r       <= max_nxt;
      top_r       <= top_nxt;
      created_r   <= created_nxt;
      act_r       <= act_nxt;
      acq_r       <= acq_nxt;
      rel_r       <= rel_nxt;
      cre_r       <= cre_nxt;
      reuse_r     <= reuse_nxt;
      err_r       <= err_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    id_r  <= id_nxt;
    pop_r <= pop_nxt;
    out_r <= out_nxt;
  end

  // Status toward the controller.
  assign stat.clr_last  = (clr_addr_r == LAST_IDX);
  assign stat.pop_avail = (in_data.command == cipa_pkg::CMD_ACQUIRE) && (top_r != '0);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/cipa_checker.sv
// Port-level checks for the connection ID pool allocator, bound to the top level.
module cipa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input cipa_pkg::out_t            out_data,
  input logic                      cfg_we
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset starts the clear pass, so no request is taken right after it.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken right after reset");

  // A limit write starts the clear pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request taken right after a limit write");

  // Only a grant carries an ID and a use count.
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == cipa_pkg::STAT_EXHAUSTED ||
                  out_data.status == cipa_pkg::STAT_RELEASED ||
                  out_data.status == cipa_pkg::STAT_INVALID)
    |-> out_data.granted_id == '0 && out_data.grant_uses == '0)
    else $error("ID or use count reported without a grant");

  // Every existing ID is either idle or handed out.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      cipa_pkg::ID_W'(out_data.idle_count + out_data.active_count) ==
      out_data.created_count)
    else $error("idle plus active differs from created");

endmodule

bind connection_id_pool_allocator cipa_checker u_cipa_checker (.*);

FILE: tb/connection_id_pool_allocator_tb.sv
// Self-checking testbench for the connection ID pool allocator, with its own pool predictor.
module connection_id_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL        = cipa_pkg::POOL_DEPTH_DEF;
  localparam int unsigned SLOT_W      = $clog2(POOL);
  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned ID_W        = cipa_pkg::ID_W;
  localparam int unsigned USE_W       = cipa_pkg::USE_W;
  localparam int unsigned STAT_W      = cipa_pkg::STAT_W;

  // Tracks the free stack, flags and counters of the pool and checks each result beat.
  class id_pool_tracker;
    bit [ID_W-1:0]   limit;
    bit [SLOT_W-1:0] free_stack [POOL];
    bit              active_flags [POOL];
    bit [USE_W-1:0]  use_counts [POOL];
    int unsigned     stack_top;
    int unsigned     created_ids;
    int unsigned     active_total;
    bit [STAT_W-1:0] acquired_total;
    bit [STAT_W-1:0] released_total;
    bit [STAT_W-1:0] created_total;
    bit [STAT_W-1:0] reuse_total;
    bit [STAT_W-1:0] error_total;
    cipa_pkg::out_t  expected_results [$];
    int unsigned     mismatches;

    function new();
      mismatches = 0;
      reload(cipa_pkg::MAX_ENTRIES_RST);
    endfunction

    // A clear leaves max(limit/4, 4) IDs on the stack with the highest one on top.
    function void reload(bit [ID_W-1:0] lim);
      int unsigned fill;
      int unsigned i;
      limit = lim;
      fill = lim / 4;
      if (fill < cipa_pkg::MIN_PREFILL) fill = cipa_pkg::MIN_PREFILL;
      if (fill > POOL) fill = POOL;
      for (i = 0; i < POOL; i++) begin
        free_stack[i]   = (i < fill) ? SLOT_W'(i) : '0;
        active_flags[i] = 1'b0;
        use_counts[i]   = '0;
      end
      stack_top      = fill;
      created_ids    = fill;
      active_total   = 0;
      acquired_total = '0;
      released_total = '0;
      created_total  = '0;
      reuse_total    = '0;
      error_total    = '0;
    endfunction

    // Applies one accepted request beat and queues the result it must produce.
    function void note_request(cipa_pkg::in_t req);
      cipa_pkg::out_t r;
      int unsigned    slot;
      int unsigned    id;
      r = '0;
      if (req.command == cipa_pkg::CMD_ACQUIRE) begin
        if (stack_top > 0) begin
          // Served from the top of the free stack.
          stack_top--;
          slot = free_stack[stack_top];
          active_flags[slot] = 1'b1;
          if (use_counts[slot] != cipa_pkg::USE_MAX) use_counts[slot]++;
          r.status     = cipa_pkg::STAT_REUSED;
          r.granted_id = ID_W'(slot + 1);
          r.grant_uses = use_counts[slot];
          active_total++;
          acquired_total++;
          reuse_total++;
        end else if (created_ids < limit && created_ids < POOL) begin
          // Stack is dry but the pool may still grow by one ID.
          slot = created_ids;
          created_ids++;
          active_flags[slot] = 1'b1;
          use_counts[slot]   = 1;
          r.status     = cipa_pkg::STAT_CREATED;
          r.granted_id = ID_W'(slot + 1);
          r.grant_uses = 1;
          active_total++;
          acquired_total++;
          created_total++;
        end else begin
          r.status = cipa_pkg::STAT_EXHAUSTED;
          error_total++;
        end
      end else begin
        id = req.entry_id;
        if (id == 0 || id > created_ids || id > POOL || !active_flags[id - 1] ||
            stack_top >= POOL) begin
          // Refused release leaves every piece of state alone.
          r.status = cipa_pkg::STAT_INVALID;
        end else begin
          active_flags[id - 1]  = 1'b0;
          free_stack[stack_top] = SLOT_W'(id - 1);
          stack_top++;
          if (active_total > 0) active_total--;
          released_total++;
          r.status = cipa_pkg::STAT_RELEASED;
        end
      end
      r.idle_count     = ID_W'(stack_top);
      r.active_count   = ID_W'(active_total);
      r.created_count  = ID_W'(created_ids);
      r.acquired_total = acquired_total;
      r.released_total = released_total;
      r.created_total  = created_total;
      r.reuse_total    = reuse_total;
      r.error_total    = error_total;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [STAT_W-1:0] want,
                                logic [STAT_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s differs, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one accepted result beat with the oldest outstanding prediction.
    function void check_result(cipa_pkg::out_t got);
      cipa_pkg::out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("granted_id", want.granted_id, got.granted_id);
      compare_field("grant_uses", want.grant_uses, got.grant_uses);
      compare_field("idle_count", want.idle_count, got.idle_count);
      compare_field("active_count", want.active_count, got.active_count);
      compare_field("created_count", want.created_count, got.created_count);
      compare_field("acquired_total", want.acquired_total, got.acquired_total);
      compare_field("released_total", want.released_total, got.released_total);
      compare_field("created_total", want.created_total, got.created_total);
      compare_field("reuse_total", want.reuse_total, got.reuse_total);
      compare_field("error_total", want.error_total, got.error_total);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Returns a random ID that is currently handed out, or 0 if there is none.
    function int unsigned pick_active();
      int unsigned start;
      int unsigned k;
      int unsigned slot;
      if (active_total == 0) return 0;
      start = $urandom_range(created_ids - 1, 0);
      for (k = 0; k < created_ids; k++) begin
        slot = (start + k) % created_ids;
        if (active_flags[slot]) return slot + 1;
      end
      return 0;
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  cipa_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_ready = 1'b0;
  cipa_pkg::out_t  out_data;
  logic            cfg_we;
  logic [ID_W-1:0] cfg_wdata;

  id_pool_tracker  pool = new();
  int unsigned     sender_idle_pct = 0;
  int unsigned     receiver_stall_pct = 0;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;
  bit [ID_W-1:0]   phase_limits [8];

  connection_id_pool_allocator #(
    .POOL_DEPTH(POOL)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready drops in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < receiver_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(13, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result beat is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) pool.check_result(out_data);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request beat and holds it until it is taken.
  task automatic send_beat(input cipa_pkg::in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pool.note_request(beat);
  endtask

  task automatic acquire();
    cipa_pkg::in_t beat;
    beat.command  = cipa_pkg::CMD_ACQUIRE;
    beat.entry_id = ID_W'($urandom_range(POOL, 0));
    send_beat(beat);
  endtask

  task automatic release_id(input int unsigned id);
    cipa_pkg::in_t beat;
    beat.command  = cipa_pkg::CMD_RELEASE;
    beat.entry_id = ID_W'(id);
    send_beat(beat);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
  endtask

  // Stops sending until every outstanding result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pool.pending() != 0);
  endtask

  // The limit is only written with the block idle; the write starts a clear pass.
  task automatic write_limit(input bit [ID_W-1:0] lim);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool.reload(lim);
  endtask

  // Release IDs that are mostly refused: none, random, existing but maybe idle, the top one.
  function automatic int unsigned stray_id();
    case ($urandom_range(3))
      0:       return 0;
      1:       return $urandom_range(POOL, 0);
      2:       return $urandom_range(pool.created_ids, 1);
      default: return POOL;
    endcase
  endfunction

  // Mostly acquires and releases of live IDs, with some stray releases mixed in.
  // Draining pauses only happen while the sender is allowed to idle.
  task automatic run_mixed(input int unsigned count, input int unsigned acq_pct);
    int unsigned k;
    int unsigned pick;
    for (k = 0; k < count; k++) begin
      maybe_idle();
      if (sender_idle_pct != 0 && $urandom_range(99) < 3) wait_for_results();
      pick = $urandom_range(99);
      if (pick < acq_pct) acquire();
      else if (pick < 92 && pool.active_total != 0) release_id(pool.pick_active());
      else release_id(stray_id());
    end
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit gives 500 IDs on the stack. Refused releases first: no ID,
    // an ID never created, an ID that exists but is not handed out.
    release_id(0);
    release_id(POOL);
    release_id(1);
    acquire();
    acquire();
    release_id(500);
    release_id(500);
    acquire();

    // Limit below four: four IDs are loaded anyway and none is ever created.
    write_limit(1);
    repeat (5) acquire();
    release_id(2);

    // Small limit: the stack runs dry, two IDs get created, then the pool is exhausted.
    write_limit(6);
    repeat (7) acquire();
    release_id(6);
    acquire();

    // Limit at the pool depth: a long run of mostly acquires from a deep stack.
    write_limit(ID_W'(POOL));
    sender_idle_pct    = 5;
    receiver_stall_pct = 5;
    repeat (280) begin
      maybe_idle();
      if ($urandom_range(99) < 95 || pool.active_total == 0) acquire();
      else release_id(pool.pick_active());
    end

    // Mixed traffic under a series of limits, with and without idling.
    phase_limits = '{12'd1, 12'd7, 12'd2047, 12'd300, 12'd16, 12'd3, 12'd0, 12'd40};
    phase_limits[6] = ID_W'($urandom_range(POOL, 1));
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      sender_idle_pct    = (p % 3 == 0) ? 0 : 10 + 15 * (p % 2);
      receiver_stall_pct = (p % 3 == 1) ? 0 : 10 + 15 * ((p + 1) % 2);
      run_mixed(100, $urandom_range(70, 40));
    end

    // Closing stretch at the reset limit with no idling on either side.
    write_limit(cipa_pkg::MAX_ENTRIES_RST);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_mixed(100, 55);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (pool.mismatches == 0 && pool.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
